// ===== hw/rtl/svpwm_pkg.sv =====
// shared types and constants for the space vector pwm duty block
`timescale 1ns / 1ps

package svpwm_pkg;

  // register indexes on the write port
  localparam int REG_INDEX_W = 1;
  localparam logic [REG_INDEX_W-1:0] REG_BUS_VOLTAGE = 1'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PWM_PERIOD  = 1'd1;
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] BUS_VOLTAGE_RESET = 16'd8400;
  localparam logic [CFG_W-1:0] PWM_PERIOD_RESET  = 16'd8400;

  // sin 60 in q15, and the phase time limit
  localparam logic signed [15:0] SIN60_Q15  = 16'sd28378;
  localparam logic [14:0]        Q15_ROUND  = 15'h7fff;
  localparam int                 TIME_W     = 15;
  localparam logic signed [TIME_W-1:0] TIME_LIMIT = 15'sd8399;

  // working width of the helper terms and the raw phase times
  localparam int T_W = 19;

  // sector codes
  localparam int SECTOR_W = 3;
  localparam logic [SECTOR_W-1:0] SECTOR_1     = 3'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_2     = 3'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_3     = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_4     = 3'd4;
  localparam logic [SECTOR_W-1:0] SECTOR_5     = 3'd5;
  localparam logic [SECTOR_W-1:0] SECTOR_6     = 3'd6;
  localparam logic [SECTOR_W-1:0] SECTOR_START = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_FLIP  = 3'd7;

  // magnitude of a clamped time times the period fits in 30 bits
  localparam int MAG_W     = TIME_W - 1;
  localparam int DIVISOR_W = CFG_W;
  localparam int NUM_W     = MAG_W + CFG_W;
  localparam int DIV_STEPS = NUM_W;

  localparam int LANES = 3;

  typedef struct packed {
    logic signed [15:0] alpha_voltage;
    logic signed [15:0] beta_voltage;
  } svpwm_req_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [15:0]         compare_a;
    logic [15:0]         compare_b;
    logic [15:0]         compare_c;
  } svpwm_rsp_t;

  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/svpwm_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module svpwm_div
  import svpwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  input  logic [DIVISOR_W-1:0] divisor,
  output div_rsp_t             rsp
);

  logic                 vld  [1:DIV_STEPS];
  logic [DIVISOR_W-1:0] rem  [1:DIV_STEPS];
  logic [NUM_W-1:0]     word [1:DIV_STEPS];

  for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_step
    logic                 src_vld;
    logic [DIVISOR_W-1:0] src_rem;
    logic [NUM_W-1:0]     src_word;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;

    if (gi == 0) begin : g_first
      assign src_vld  = req.vld;
      assign src_rem  = '0;
      assign src_word = req.num;
    end else begin : g_rest
      assign src_vld  = vld[gi];
      assign src_rem  = rem[gi];
      assign src_word = word[gi];
    end

    assign trial = {src_rem, src_word[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gi+1] <= 1'b0;
      end else begin
        vld[gi+1] <= src_vld;
      end
    end

    // borrow out means the divisor did not fit
    always_ff @(posedge clk) begin
      rem[gi+1]  <= diff[DIVISOR_W] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
      word[gi+1] <= {src_word[NUM_W-2:0], ~diff[DIVISOR_W]};
    end
  end

  assign rsp.vld  = vld[DIV_STEPS];
  assign rsp.quot = word[DIV_STEPS];

endmodule

// ===== hw/rtl/space_vector_pwm_duty_top.sv =====
// space vector pwm duty: alpha/beta voltage pair to sector and three compare values
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// request   in         start, busy        cmd (alpha_voltage, beta_voltage)
// result    out        done (one cycle)   result (sector, compare_a..c)
// config    in         wr_en              wr_index, wr_data
//
// a request can be taken every cycle while busy is low; its result passes through
// 5 arithmetic stages, a 30 stage bit-per-stage divider and an output register
// busy is high only while rst is high; reset clears every valid bit and
// loads both registers with 8400
// the receiver cannot stall, so nothing ever waits inside the pipeline

module space_vector_pwm_duty_top
  import svpwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  svpwm_req_t             cmd,
  output logic                   done,
  output svpwm_rsp_t             result,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]       wr_data
);

  localparam int LATENCY = DIV_STEPS + 6;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [LANES-1:0]    neg;
  } side_t;

  function automatic logic signed [TIME_W-1:0] clamp_time(input logic signed [T_W-1:0] t);
    logic signed [TIME_W-1:0] r;
    if (t > T_W'(TIME_LIMIT)) begin
      r = TIME_LIMIT;
    end else if (t < -T_W'(TIME_LIMIT)) begin
      r = -TIME_LIMIT;
    end else begin
      r = t[TIME_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] bus_voltage;
  logic [CFG_W-1:0] pwm_period;
  logic [CFG_W-1:0] divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_voltage <= BUS_VOLTAGE_RESET;
      pwm_period  <= PWM_PERIOD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_BUS_VOLTAGE: bus_voltage <= wr_data;
        REG_PWM_PERIOD:  pwm_period  <= wr_data;
        default: ;
      endcase
    end
  end

  // a zero bus voltage divides as one
  assign divisor = (bus_voltage == '0) ? CFG_W'(1) : bus_voltage;

  assign busy = rst;

  // stage 1: sin 60 product and truncated half of beta
  logic               v1;
  logic signed [31:0] s1_prod;
  logic signed [15:0] s1_bh;
  logic signed [15:0] s1_beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod <= cmd.alpha_voltage * SIN60_Q15;
    s1_bh   <= (cmd.beta_voltage + $signed(16'(cmd.beta_voltage[15]))) >>> 1;
    s1_beta <= cmd.beta_voltage;
  end

  // stage 2: t1 and t2, q15 scaling truncates toward zero
  logic                  v2;
  logic signed [T_W-1:0] s2_t1;
  logic signed [T_W-1:0] s2_t2;
  logic signed [31:0]    s1_bias;
  logic signed [16:0]    s1_scaled;

  always_comb begin
    s1_bias   = s1_prod + (s1_prod[31] ? 32'(Q15_ROUND) : 32'sd0);
    s1_scaled = s1_bias[31:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s2_t1 <= T_W'(s1_beta);
    s2_t2 <= T_W'(s1_bh) + T_W'(s1_scaled);
  end

  // stage 3: sector from the signs of t1, t2 and t3 = t2 - t1
  logic                  v3;
  logic [SECTOR_W-1:0]   s3_sector;
  logic signed [T_W-1:0] s3_t1;
  logic signed [T_W-1:0] s3_t2;
  logic [SECTOR_W-1:0]   sector_next;

  always_comb begin
    sector_next = SECTOR_START - SECTOR_W'(s2_t2 > 0) - SECTOR_W'(s2_t2 > s2_t1);
    if (s2_t1 < 0) begin
      sector_next = SECTOR_FLIP - sector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s3_sector <= sector_next;
    s3_t1     <= s2_t1;
    s3_t2     <= s2_t2;
  end

  // stage 4: phase times for the sector, clamped
  logic                     v4;
  logic [SECTOR_W-1:0]      s4_sector;
  logic signed [TIME_W-1:0] s4_time [LANES];
  logic signed [T_W-1:0]    raw     [LANES];

  always_comb begin
    case (s3_sector) inside
      SECTOR_1, SECTOR_4: begin
        raw[0] = s3_t2;
        raw[1] = (s3_t1 <<< 1) - s3_t2;
        raw[2] = -s3_t2;
      end
      SECTOR_2, SECTOR_5: begin
        raw[0] = (s3_t2 <<< 1) - s3_t1;
        raw[1] = s3_t1;
        raw[2] = -s3_t1;
      end
      default: begin
        raw[0] = s3_t2 - s3_t1;
        raw[1] = s3_t1 - s3_t2;
        raw[2] = -(s3_t1 + s3_t2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s4_sector <= s3_sector;
    for (int i = 0; i < LANES; i++) begin
      s4_time[i] <= clamp_time(raw[i]);
    end
  end

  // stage 5: magnitude times period, sign kept aside
  logic                     v5;
  side_t                    s5_side;
  logic [NUM_W-1:0]         s5_num [LANES];
  logic signed [TIME_W-1:0] t_abs  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      t_abs[i] = s4_time[i][TIME_W-1] ? -s4_time[i] : s4_time[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s5_side.sector <= s4_sector;
    for (int i = 0; i < LANES; i++) begin
      s5_side.neg[i] <= s4_time[i][TIME_W-1];
      s5_num[i]      <= NUM_W'(t_abs[i][MAG_W-1:0]) * NUM_W'(pwm_period);
    end
  end

  // division by the bus voltage, one lane per phase
  div_rsp_t div_rsp [LANES];

  for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
    div_req_t lane_req;
    assign lane_req.vld = v5;
    assign lane_req.num = s5_num[gl];

    svpwm_div u_div (
      .clk     (clk),
      .rst     (rst),
      .req     (lane_req),
      .divisor (divisor),
      .rsp     (div_rsp[gl])
    );
  end

  // sector and signs ride alongside the divider
  side_t side_line [DIV_STEPS];

  always_ff @(posedge clk) begin
    side_line[0] <= s5_side;
    for (int i = 1; i < DIV_STEPS; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end

  // output stage: restore sign, floor halve, offset by half period, saturate
  logic signed [NUM_W:0]   q_s   [LANES];
  logic signed [NUM_W:0]   half  [LANES];
  logic signed [NUM_W+1:0] cmp   [LANES];
  logic [15:0]             cmp_sat [LANES];
  logic signed [NUM_W+1:0] per_half;

  always_comb begin
    per_half = $signed((NUM_W+2)'(pwm_period[CFG_W-1:1]));
    for (int i = 0; i < LANES; i++) begin
      q_s[i]  = side_line[DIV_STEPS-1].neg[i] ? -$signed({1'b0, div_rsp[i].quot})
                                              :  $signed({1'b0, div_rsp[i].quot});
      half[i] = q_s[i] >>> 1;
      cmp[i]  = (NUM_W+2)'(half[i]) + per_half;
      if (cmp[i] < 0) begin
        cmp_sat[i] = '0;
      end else if (cmp[i] > $signed((NUM_W+2)'(16'hffff))) begin
        cmp_sat[i] = 16'hffff;
      end else begin
        cmp_sat[i] = cmp[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_rsp[0].vld;
    end
  end

  always_ff @(posedge clk) begin
    result.sector    <= side_line[DIV_STEPS-1].sector;
    result.compare_a <= cmp_sat[0];
    result.compare_b <= cmp_sat[1];
    result.compare_c <= cmp_sat[2];
  end

`ifndef SYNTH
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.sector >= SECTOR_1 && result.sector <= SECTOR_6))
    else $error("sector out of range on result");

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted request produced no result");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching request");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    div_rsp[0].vld == div_rsp[1].vld && div_rsp[1].vld == div_rsp[2].vld)
    else $error("divider lanes out of step");
`endif

endmodule
